[src/alr_pkg.sv]
`default_nettype none

package alr_pkg;

  // Request kinds carried by in_req_type
  typedef logic [1:0] req_t;
  localparam req_t REQ_SAMPLE = 2'd0;
  localparam req_t REQ_MODE   = 2'd1;
  localparam req_t REQ_CLEAR  = 2'd2;

  // Looper modes
  typedef logic [1:0] mode_t;
  localparam mode_t MODE_IDLE = 2'd0;
  localparam mode_t MODE_REC  = 2'd1;
  localparam mode_t MODE_DUB  = 2'd2;
  localparam mode_t MODE_PLAY = 2'd3;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_DRY_GAIN   = 2'd0;
  localparam cfg_idx_t CFG_WET_GAIN   = 2'd1;
  localparam cfg_idx_t CFG_MAX_LENGTH = 2'd2;

  // Gains are unsigned Q2.14
  localparam int GAIN_BITS = 16;
  localparam int GAIN_FRAC = 14;
  localparam int LEN_BITS  = 17;
  localparam int CFG_BITS  = 17;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET   = 16'd16384;
  localparam logic [LEN_BITS-1:0]  MAX_LEN_RESET = 17'd65536;

endpackage

`default_nettype wire

[src/audio_loop_recorder.sv]
`default_nettype none

// Audio loop recorder: record, overdub and play back one loop of samples.
// Input channel (in_valid/in_ready): each transaction is a sample, a mode
// change or a loop clear. Only sample transactions give an output
// transaction on out_valid/out_ready, in the order they were accepted.
// Configuration channel (cfg_valid/cfg_ready, always ready): index 0 dry gain,
// 1 wet gain, 2 max loop length; write only while the block is idle.
// Path: an accepted sample is registered in stage 1, then stage 2, then the
// output register. Throughput: one transaction per cycle while the output is
// not stalled, set by the single loop memory that takes one read (at accept)
// and one write (as stage 1 moves on) per cycle; overlapping accesses to one entry are forwarded.
// Pipeline: accept/read, mix multiply and write back, accumulate into the
// output register. Each stage moves whenever the stage after it is empty or
// moving, so a stalled receiver holds the output and the pipeline fills up
// behind it before in_ready drops.
// Reset (rst_n low, synchronous): idle mode, empty loop, unity gains, max
// length 65536, pipeline empty. The loop memory is not cleared; the mode
// rules never read an entry before it has been written.
module audio_loop_recorder #(
  parameter int LOOP_DEPTH  = 65536,
  parameter int SAMPLE_BITS = 24
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  alr_pkg::req_t                in_req_type,
  input  wire signed [SAMPLE_BITS-1:0] in_sample_in,
  input  alr_pkg::mode_t               in_new_mode,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] out_sample_out,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  alr_pkg::cfg_idx_t            cfg_index,
  input  wire [alr_pkg::CFG_BITS-1:0]  cfg_data
);
  import alr_pkg::*;

  localparam int AW     = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
  localparam int CW     = $clog2(LOOP_DEPTH + 1);
  localparam int LW     = (CW > LEN_BITS) ? CW : LEN_BITS;
  localparam int PROD_W = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int ACC_W  = PROD_W + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(LOOP_DEPTH);
  localparam logic [LW-1:0] DEPTH_L = LW'(LOOP_DEPTH);
  localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] ROUND_C = ACC_W'(1) <<< (GAIN_FRAC - 1);

  // Configuration registers
  logic [GAIN_BITS-1:0] dry_gain_r, wet_gain_r;
  logic [LEN_BITS-1:0]  max_len_r;

  // Loop control state
  mode_t         mode_r, mode_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] length_r, length_nxt;
  logic [AW-1:0] pos_r, pos_nxt;

  // Loop memory
  logic [SAMPLE_BITS-1:0] mem [LOOP_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_data_r;

  // Stage 1: operand fetch, write back
  logic                          s1_valid_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic                          s1_mix_r, s1_dub_r, s1_rec_r;
  logic [AW-1:0]                 s1_addr_r;
  logic                          s1_fwd_r;
  logic [SAMPLE_BITS-1:0]        fwd_data_r;

  // Stage 2: products
  logic                     s2_valid_r;
  logic signed [PROD_W-1:0] s2_dry_r, s2_wet_r;

  // Output register
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;

  // Handshake and flow
  logic out_free, s2_free, s1_free;
  logic accept, acc_sample;

  // Stage 0 decisions
  logic          rec_write, mix_ok, limit_hit;
  logic [CW-1:0] count_inc, pos_inc;
  logic [LW-1:0] max_ext, limit_len;

  // Stage 1 datapath
  logic signed [SAMPLE_BITS-1:0] stored;
  logic signed [SAMPLE_BITS:0]   dub_sum;
  logic signed [SAMPLE_BITS-1:0] dub_sat;
  logic [SAMPLE_BITS-1:0]        wr_data;
  logic                          wr_fire;
  logic signed [PROD_W-1:0]      p_dry, p_wet;

  // Stage 2 datapath
  logic signed [ACC_W-1:0] acc, acc_sh;
  logic                    acc_fits;
  logic signed [SAMPLE_BITS-1:0] mix_sat;

  // Flow control: a stage loads when the next one is empty or moving
  assign out_free   = !out_valid_r || out_ready;
  assign s2_free    = !s2_valid_r || out_free;
  assign s1_free    = !s1_valid_r || s2_free;
  assign in_ready   = s1_free;
  assign accept     = in_valid && in_ready;
  assign acc_sample = accept && (in_req_type == REQ_SAMPLE);
  assign cfg_ready  = 1'b1;
  assign out_valid  = out_valid_r;
  assign out_sample_out = out_data_r;

  // Recording limit, clamped to 1..LOOP_DEPTH
  always_comb begin
    max_ext = LW'(max_len_r);
    if (max_ext == '0) begin
      limit_len = LW'(1);
    end else if (max_ext > DEPTH_L) begin
      limit_len = DEPTH_L;
    end else begin
      limit_len = max_ext;
    end
  end

  assign rec_write = (mode_r == MODE_REC) && (count_r < DEPTH_C);
  assign count_inc = rec_write ? count_r + CW'(1) : count_r;
  assign limit_hit = LW'(count_inc) >= limit_len;
  assign mix_ok    = ((mode_r == MODE_DUB) || (mode_r == MODE_PLAY)) && (length_r != '0);
  assign pos_inc   = CW'(pos_r) + CW'(1);

  // Next loop control state for an accepted transaction
  always_comb begin
    mode_nxt   = mode_r;
    count_nxt  = count_r;
    length_nxt = length_r;
    pos_nxt    = pos_r;
    if (accept) begin
      unique case (in_req_type)
        REQ_SAMPLE: begin
          if (mode_r == MODE_REC) begin
            count_nxt = count_inc;
            if (limit_hit) begin
              length_nxt = count_inc;
              pos_nxt    = '0;
              mode_nxt   = MODE_PLAY;
            end
          end else if (mix_ok) begin
            pos_nxt = (pos_inc >= length_r) ? '0 : pos_inc[AW-1:0];
          end
        end
        REQ_MODE: begin
          if (in_new_mode == MODE_REC) begin
            count_nxt  = '0;
            length_nxt = '0;
            pos_nxt    = '0;
          end else if (in_new_mode == MODE_PLAY && mode_r == MODE_REC) begin
            length_nxt = count_r;
            pos_nxt    = '0;
          end
          mode_nxt = in_new_mode;
        end
        REQ_CLEAR: begin
          count_nxt  = '0;
          length_nxt = '0;
          pos_nxt    = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold configuration and loop control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dry_gain_r <= GAIN_RESET;
      wet_gain_r <= GAIN_RESET;
      max_len_r  <= MAX_LEN_RESET;
      mode_r     <= MODE_IDLE;
      count_r    <= '0;
      length_r   <= '0;
      pos_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_DRY_GAIN:   dry_gain_r <= cfg_data[GAIN_BITS-1:0];
          CFG_WET_GAIN:   wet_gain_r <= cfg_data[GAIN_BITS-1:0];
          CFG_MAX_LENGTH: max_len_r  <= cfg_data[LEN_BITS-1:0];
          default: begin
          end
        endcase
      end
      mode_r   <= mode_nxt;
      count_r  <= count_nxt;
      length_r <= length_nxt;
      pos_r    <= pos_nxt;
    end
  end

  // Stage 1 operand: forward a write that landed on the same edge as the read
  assign stored  = s1_fwd_r ? $signed(fwd_data_r) : $signed(rd_data_r);
  assign dub_sum = {stored[SAMPLE_BITS-1], stored} + {s1_sample_r[SAMPLE_BITS-1], s1_sample_r};
  assign dub_sat = (dub_sum[SAMPLE_BITS] != dub_sum[SAMPLE_BITS-1]) ?
                   (dub_sum[SAMPLE_BITS] ? SMIN : SMAX) : dub_sum[SAMPLE_BITS-1:0];
  assign wr_data = s1_dub_r ? dub_sat : s1_sample_r;
  assign wr_fire = s1_valid_r && (s1_rec_r || s1_dub_r) && s2_free;

  // Memory: read at accept, write back when stage 1 moves on
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[s1_addr_r] <= wr_data;
    end
    if (acc_sample && mix_ok) begin
      rd_data_r <= mem[pos_r];
    end
  end

  // Load stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= acc_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (acc_sample) begin
      s1_sample_r <= in_sample_in;
      s1_rec_r    <= rec_write;
      s1_mix_r    <= mix_ok;
      s1_dub_r    <= mix_ok && (mode_r == MODE_DUB);
      s1_addr_r   <= rec_write ? count_r[AW-1:0] : pos_r;
      s1_fwd_r    <= wr_fire && (s1_addr_r == pos_r);
      fwd_data_r  <= wr_data;
    end
  end

  // Stage 1 multiplies
  assign p_dry = PROD_W'(s1_sample_r) * PROD_W'($signed({1'b0, dry_gain_r}));
  assign p_wet = s1_mix_r ? PROD_W'(stored) * PROD_W'($signed({1'b0, wet_gain_r})) : '0;

  // Advance into stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_free) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid_r) begin
      s2_dry_r <= p_dry;
      s2_wet_r <= p_wet;
    end
  end

  // Stage 2: accumulate, round half up, drop fraction, saturate
  assign acc      = ACC_W'(s2_dry_r) + ACC_W'(s2_wet_r) + ROUND_C;
  assign acc_sh   = acc >>> GAIN_FRAC;
  assign acc_fits = (&acc_sh[ACC_W-1:SAMPLE_BITS-1]) || !(|acc_sh[ACC_W-1:SAMPLE_BITS-1]);
  assign mix_sat  = acc_fits ? acc_sh[SAMPLE_BITS-1:0] : (acc_sh[ACC_W-1] ? SMIN : SMAX);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid_r) begin
      out_data_r <= mix_sat;
    end
  end

endmodule

`default_nettype wire
